@@ hw/rtl/disc_drive_command_register_page_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the disc drive command register page
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef DISC_DRIVE_COMMAND_REGISTER_PAGE_MACROS_SVH
`define DISC_DRIVE_COMMAND_REGISTER_PAGE_MACROS_SVH

// same-cycle implication
`define DDCRP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddcrp: property failed");

// next-cycle implication
`define DDCRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddcrp: property failed");

`endif

@@ hw/rtl/ddcrp_pkg.sv @@
// ---------------------------------------------------------------------------
// ddcrp_pkg
// Types, register offsets and reset values of the drive register page.
// ---------------------------------------------------------------------------
`default_nettype none

package ddcrp_pkg;

  localparam int PARAM_DEPTH = 16;
  localparam int MAX_SECTORS = 4096;
  localparam int PAGE_REGS   = 256;

  localparam int BUS_W      = 32;
  localparam int ADDR_W     = 29;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;
  localparam int PAGE_AW    = $clog2(PAGE_REGS);
  localparam int PFILL_W    = $clog2(PARAM_DEPTH + 1);
  localparam int PIDX_W     = $clog2(PARAM_DEPTH);
  localparam int RESULT_LEN = 16;
  localparam int RCNT_W     = $clog2(RESULT_LEN + 1);
  localparam int READ_PARAMS = 8;

  localparam logic [ADDR_W:0] WINDOW_SIZE = (ADDR_W + 1)'(32'h1000);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [BYTE_W-1:0] R_NCMD    = 8'h04;
  localparam logic [BYTE_W-1:0] R_READY   = 8'h05;
  localparam logic [BYTE_W-1:0] R_ERROR   = 8'h06;
  localparam logic [BYTE_W-1:0] R_BREAK   = 8'h07;
  localparam logic [BYTE_W-1:0] R_ISTAT   = 8'h08;
  localparam logic [BYTE_W-1:0] R_STATUS  = 8'h0A;
  localparam logic [BYTE_W-1:0] R_STICKY  = 8'h0B;
  localparam logic [BYTE_W-1:0] R_TYPE    = 8'h0F;
  localparam logic [BYTE_W-1:0] R_SCMD    = 8'h16;
  localparam logic [BYTE_W-1:0] R_SDATA   = 8'h17;
  localparam logic [BYTE_W-1:0] R_SRESULT = 8'h18;

  localparam logic [BYTE_W-1:0] NODATA_BIT  = 8'h40;
  localparam logic [BYTE_W-1:0] ISTAT_DONE  = 8'h02;
  localparam logic [BYTE_W-1:0] ISTAT_DATA  = 8'h01;
  localparam logic [BYTE_W-1:0] ERR_ABORT   = 8'h01;
  localparam logic [BYTE_W-1:0] NCMD_READ_A = 8'h06;
  localparam logic [BYTE_W-1:0] NCMD_READ_B = 8'h08;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIA        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_VALUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAY_STATUS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_STATUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NODISC_TYPE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RCFG_OPCODE  = 3'd6;

  localparam logic [ADDR_W-1:0] RST_PAGE_BASE    = 29'd524296192;
  localparam logic              RST_MEDIA        = 1'b0;
  localparam logic [BYTE_W-1:0] RST_READY_VALUE  = 8'd76;
  localparam logic [BYTE_W-1:0] RST_TRAY_STATUS  = 8'd1;
  localparam logic [BYTE_W-1:0] RST_PAUSE_STATUS = 8'd10;
  localparam logic [BYTE_W-1:0] RST_NODISC_TYPE  = 8'd0;
  localparam logic [BYTE_W-1:0] RST_RCFG_OPCODE  = 8'd65;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_ram;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ddcrp_ram.sv @@
// ---------------------------------------------------------------------------
// ddcrp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ddcrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/ddcrp_ctrl.sv @@
// ---------------------------------------------------------------------------
// ddcrp_ctrl
// Sequencer: capture an item, execute it, fetch page data for RAM reads, hold the result.
// ---------------------------------------------------------------------------
`default_nettype none

module ddcrp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ddcrp_pkg::ctrl_cmd_t     cmd,
  input  wire ddcrp_pkg::dp_stat_t stat
);
  import ddcrp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DATA = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = stat.need_ram ? ST_DATA : ST_OUT;
      end
      ST_DATA: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = (state_r == ST_OUT);
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign cmd.load    = (state_r == ST_DATA);

endmodule

`default_nettype wire

@@ hw/rtl/ddcrp_dp.sv @@
// ---------------------------------------------------------------------------
// ddcrp_dp
// Datapath: address decode, register page, parameter FIFO, command logic.
// ---------------------------------------------------------------------------
`default_nettype none

module ddcrp_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ddcrp_pkg::ctrl_cmd_t                  cmd,
  output ddcrp_pkg::dp_stat_t                        stat,
  input  wire logic                                  cfg_we,
  input  wire logic [ddcrp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ddcrp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic [1:0]                            in_opcode,
  input  wire logic [ddcrp_pkg::BUS_W-1:0]           in_bus_address,
  input  wire logic [ddcrp_pkg::BYTE_W-1:0]          in_write_data,
  input  wire logic                                  in_transfer_ok,
  output logic      [ddcrp_pkg::BYTE_W-1:0]          out_read_data,
  output logic                                       out_hit,
  output logic                                       out_irq_pulse,
  output logic                                       out_read_issued,
  output logic      [ddcrp_pkg::BUS_W-1:0]           out_start_sector,
  output logic      [ddcrp_pkg::CNT_W-1:0]           out_sector_count
);
  import ddcrp_pkg::*;

  // configuration
  logic [ADDR_W-1:0] base_r;
  logic              media_r;
  logic [BYTE_W-1:0] ready_val_r;
  logic [BYTE_W-1:0] pause_stat_r;
  logic [BYTE_W-1:0] rcfg_op_r;

  // captured item
  op_t               op_r;
  logic [BUS_W-1:0]  addr_r;
  logic [BYTE_W-1:0] data_r;
  logic              ok_r;

  // special registers
  logic [BYTE_W-1:0] ready_r;
  logic [BYTE_W-1:0] error_r;
  logic [BYTE_W-1:0] istat_r;
  logic [BYTE_W-1:0] status_r;
  logic [BYTE_W-1:0] sticky_r;
  logic [BYTE_W-1:0] type_r;

  logic [BYTE_W-1:0]  fifo_r [PARAM_DEPTH];
  logic [PFILL_W-1:0] pfill_r;
  logic [PFILL_W-1:0] sfill_r;
  logic [RCNT_W-1:0]  rcount_r;
  logic [RCNT_W-1:0]  rpos_r;
  logic [PAGE_REGS-1:0] valid_r;

  // result
  logic [BYTE_W-1:0] rdata_r;
  logic              hit_r;
  logic              irq_r;
  logic              issued_r;
  logic [BUS_W-1:0]  sector_r;
  logic [CNT_W-1:0]  count_r;
  logic              use_ram_r;
  logic              ram_valid_r;

  logic [ADDR_W-1:0]  phys;
  logic               in_win;
  logic [BYTE_W-1:0]  off;
  logic               in_page;
  logic               is_rd;
  logic               is_wr;
  logic               ram_rd;
  logic               ram_we;
  logic [PAGE_AW-1:0] page_idx;
  logic [BYTE_W-1:0]  ram_q;
  logic [BYTE_W-1:0]  flop_val;
  logic               ncmd;
  logic               rd_cmd;
  logic [BUS_W-1:0]   sec;
  logic [BUS_W-1:0]   cnt_raw;
  logic [BUS_W-1:0]   cnt_cl;
  logic               issue;
  logic [BYTE_W-1:0]  ibits;

  always_comb begin
    phys     = addr_r[ADDR_W-1:0];
    in_win   = ({1'b0, phys} >= {1'b0, base_r}) &&
               ({1'b0, phys} < ({1'b0, base_r} + WINDOW_SIZE));
    off      = phys[BYTE_W-1:0] - base_r[BYTE_W-1:0];
    in_page  = ({1'b0, off} < (BYTE_W + 1)'(PAGE_REGS));
    is_rd    = (op_r == OP_READ) && in_win && in_page;
    is_wr    = (op_r == OP_WRITE) && in_win && in_page;
    page_idx = off[PAGE_AW-1:0];

    ram_rd = is_rd && (off != R_ERROR) && (off != R_BREAK) && (off != R_SDATA) &&
             (off != R_SRESULT) && (off != R_READY) && (off != R_ISTAT) &&
             (off != R_STATUS) && (off != R_STICKY) && (off != R_TYPE);
    ram_we = cmd.exec && is_wr && (off != R_READY) && (off != R_ERROR) &&
             (off != R_ISTAT) && (off != R_SDATA) && (off != R_STATUS) &&
             (off != R_STICKY) && (off != R_TYPE);

    unique case (off)
      R_ERROR:  flop_val = error_r;
      R_SDATA:  flop_val = (rpos_r >= rcount_r) ? NODATA_BIT : '0;
      R_READY:  flop_val = ready_r;
      R_ISTAT:  flop_val = istat_r;
      R_STATUS: flop_val = status_r;
      R_STICKY: flop_val = sticky_r;
      R_TYPE:   flop_val = type_r;
      default:  flop_val = '0;
    endcase

    ncmd    = is_wr && (off == R_NCMD);
    rd_cmd  = (data_r == NCMD_READ_A) || (data_r == NCMD_READ_B);
    sec     = {fifo_r[3], fifo_r[2], fifo_r[1], fifo_r[0]};
    cnt_raw = {fifo_r[7], fifo_r[6], fifo_r[5], fifo_r[4]};
    cnt_cl  = (cnt_raw > BUS_W'(MAX_SECTORS)) ? BUS_W'(MAX_SECTORS) : cnt_raw;
    issue   = ncmd && rd_cmd && media_r && (pfill_r >= PFILL_W'(READ_PARAMS)) &&
              (cnt_cl != '0);
    ibits   = (issue && ok_r) ? (ISTAT_DONE | ISTAT_DATA) : ISTAT_DONE;
  end

  assign stat.need_ram = ram_rd;

  ddcrp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAGE_REGS)
  ) u_page (
    .clk   (clk),
    .we    (ram_we),
    .waddr (page_idx),
    .wdata (data_r),
    .raddr (page_idx),
    .rdata (ram_q)
  );

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r        <= RST_PAGE_BASE;
      media_r       <= RST_MEDIA;
      ready_val_r   <= RST_READY_VALUE;
      pause_stat_r  <= RST_PAUSE_STATUS;
      rcfg_op_r     <= RST_RCFG_OPCODE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_BASE:    base_r        <= cfg_wdata[ADDR_W-1:0];
        CFG_MEDIA:        media_r       <= cfg_wdata[0];
        CFG_READY_VALUE:  ready_val_r   <= cfg_wdata[BYTE_W-1:0];
        CFG_PAUSE_STATUS: pause_stat_r  <= cfg_wdata[BYTE_W-1:0];
        CFG_RCFG_OPCODE:  rcfg_op_r     <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_opcode);
      addr_r <= in_bus_address;
      data_r <= in_write_data;
      ok_r   <= in_transfer_ok;
    end
  end

  // parameter FIFO contents
  always_ff @(posedge clk) begin
    if (cmd.exec && is_wr && (off == R_READY) && (pfill_r < PFILL_W'(PARAM_DEPTH))) begin
      fifo_r[pfill_r[PIDX_W-1:0]] <= data_r;
    end
  end

  // register page state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= RST_READY_VALUE;
      error_r  <= '0;
      istat_r  <= '0;
      status_r <= RST_TRAY_STATUS;
      sticky_r <= RST_TRAY_STATUS;
      type_r   <= RST_NODISC_TYPE;
      pfill_r  <= '0;
      sfill_r  <= '0;
      rcount_r <= '0;
      rpos_r   <= '0;
      valid_r  <= '0;
    end else if (cmd.exec) begin
      if (op_r == OP_INSERT) begin
        type_r   <= data_r;
        status_r <= pause_stat_r;
        sticky_r <= sticky_r | pause_stat_r;
        ready_r  <= ready_val_r;
      end
      if (is_rd && (off == R_ERROR)) begin
        error_r <= '0;
      end
      if (is_rd && (off == R_SRESULT) && (rpos_r < rcount_r)) begin
        rpos_r <= rpos_r + RCNT_W'(1);
      end
      if (ram_we) begin
        valid_r[page_idx] <= 1'b1;
      end
      if (is_wr) begin
        priority case (off)
          R_READY: begin
            if (pfill_r < PFILL_W'(PARAM_DEPTH)) begin
              pfill_r <= pfill_r + PFILL_W'(1);
            end
          end
          R_ISTAT:  istat_r  <= istat_r & ~data_r;
          R_SDATA: begin
            if (sfill_r < PFILL_W'(PARAM_DEPTH)) begin
              sfill_r <= sfill_r + PFILL_W'(1);
            end
          end
          R_SCMD: begin
            rcount_r <= (data_r == rcfg_op_r) ? RCNT_W'(RESULT_LEN) : RCNT_W'(1);
            rpos_r   <= '0;
            sfill_r  <= '0;
          end
          R_ERROR:  error_r  <= data_r;
          R_STATUS: status_r <= data_r;
          R_STICKY: sticky_r <= data_r;
          R_TYPE:   type_r   <= data_r;
          R_NCMD: begin
            istat_r <= istat_r | ibits;
            pfill_r <= '0;
            if (rd_cmd && !(issue && ok_r)) begin
              error_r <= ERR_ABORT;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata_r     <= is_rd ? flop_val : '0;
      hit_r       <= ((op_r == OP_READ) || (op_r == OP_WRITE)) && in_win;
      irq_r       <= ncmd;
      issued_r    <= issue;
      sector_r    <= issue ? sec : '0;
      count_r     <= issue ? cnt_cl[CNT_W-1:0] : '0;
      use_ram_r   <= ram_rd;
      ram_valid_r <= valid_r[page_idx];
    end else if (cmd.load && use_ram_r) begin
      rdata_r <= ram_valid_r ? ram_q : '0;
    end
  end

  assign out_read_data    = rdata_r;
  assign out_hit          = hit_r;
  assign out_irq_pulse    = irq_r;
  assign out_read_issued  = issued_r;
  assign out_start_sector = sector_r;
  assign out_sector_count = count_r;

endmodule

`default_nettype wire

@@ hw/rtl/disc_drive_command_register_page.sv @@
// ---------------------------------------------------------------------------
// disc_drive_command_register_page
// Register page of a disc drive controller with parameter FIFO and commands.
// ---------------------------------------------------------------------------
// Sequence: an accepted item passes the execute state, then the data state for
//   reads of page bytes from the page RAM, whose read port is registered; the
//   output state holds the result until out_stall is low; no new item is taken until the block is idle again.
// Reset: synchronous; config, page special bytes, counters and page valid
//   bits take their reset values at once; no clearing pass is needed.
`default_nettype none

module disc_drive_command_register_page (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ddcrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ddcrp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic [ddcrp_pkg::BUS_W-1:0]       in_bus_address,
  input  wire logic [ddcrp_pkg::BYTE_W-1:0]      in_write_data,
  input  wire logic                              in_transfer_ok,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [ddcrp_pkg::BYTE_W-1:0]      out_read_data,
  output logic                                   out_hit,
  output logic                                   out_irq_pulse,
  output logic                                   out_read_issued,
  output logic      [ddcrp_pkg::BUS_W-1:0]       out_start_sector,
  output logic      [ddcrp_pkg::CNT_W-1:0]       out_sector_count
);
  import ddcrp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ddcrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ddcrp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_opcode        (in_opcode),
    .in_bus_address   (in_bus_address),
    .in_write_data    (in_write_data),
    .in_transfer_ok   (in_transfer_ok),
    .out_read_data    (out_read_data),
    .out_hit          (out_hit),
    .out_irq_pulse    (out_irq_pulse),
    .out_read_issued  (out_read_issued),
    .out_start_sector (out_start_sector),
    .out_sector_count (out_sector_count)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ddcrp_checker.sv @@
// ---------------------------------------------------------------------------
// ddcrp_checker
// Port-level checks of the register page, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "disc_drive_command_register_page_macros.svh"

module ddcrp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [ddcrp_pkg::BYTE_W-1:0]      out_read_data,
  input wire logic                              out_hit,
  input wire logic                              out_irq_pulse,
  input wire logic                              out_read_issued,
  input wire logic [ddcrp_pkg::BUS_W-1:0]       out_start_sector,
  input wire logic [ddcrp_pkg::CNT_W-1:0]       out_sector_count
);
  import ddcrp_pkg::*;

  `DDCRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_read_data))
  `DDCRP_ASSERT_SAME(a_miss_quiet, clk, rst_n, out_valid && !out_hit, (out_read_data == '0) && !out_irq_pulse && !out_read_issued)
  `DDCRP_ASSERT_SAME(a_no_issue_zero, clk, rst_n, out_valid && !out_read_issued, (out_start_sector == '0) && (out_sector_count == '0))
  `DDCRP_ASSERT_SAME(a_issue_ok, clk, rst_n, out_valid && out_read_issued, out_irq_pulse && out_hit && (out_sector_count != '0) && (out_sector_count <= CNT_W'(MAX_SECTORS)))
  `DDCRP_ASSERT_NEXT(a_accept_gap, clk, rst_n, in_valid && !in_stall, !out_valid && in_stall)

endmodule

bind disc_drive_command_register_page ddcrp_checker u_ddcrp_checker (.*);

`default_nettype wire

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Bench for the disc drive command register page. Bus reads, writes and
// disc-insert items go in over a valid/stall channel; a scoreboard keeps a
// copy of the page, the parameter FIFO and the result counters, predicts
// each reply and checks every reply field. Directed items open the run,
// then phases of random command sequences under several configurations.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ddcrp_pkg::*;

  typedef struct packed {
    op_t               opcode;
    logic [BUS_W-1:0]  bus_address;
    logic [BYTE_W-1:0] write_data;
    logic              transfer_ok;
  } access_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              hit;
    logic              irq_pulse;
    logic              read_issued;
    logic [BUS_W-1:0]  start_sector;
    logic [CNT_W-1:0]  sector_count;
  } reply_t;

  class page_scoreboard;
    logic [BYTE_W-1:0] page [PAGE_REGS];
    logic [BYTE_W-1:0] params [PARAM_DEPTH];
    int                param_fill;
    int                result_count;
    int                result_position;
    logic [ADDR_W-1:0] base;
    logic              media;
    logic [BYTE_W-1:0] ready_value;
    logic [BYTE_W-1:0] tray_status;
    logic [BYTE_W-1:0] pause_status;
    logic [BYTE_W-1:0] nodisc_type;
    logic [BYTE_W-1:0] rcfg_opcode;
    reply_t            replies_due [$];
    int                mismatches;

    function new();
      base = RST_PAGE_BASE;
      media = RST_MEDIA;
      ready_value = RST_READY_VALUE;
      tray_status = RST_TRAY_STATUS;
      pause_status = RST_PAUSE_STATUS;
      nodisc_type = RST_NODISC_TYPE;
      rcfg_opcode = RST_RCFG_OPCODE;
      foreach (page[i]) page[i] = '0;
      foreach (params[i]) params[i] = '0;
      page[R_READY] = ready_value;
      page[R_STATUS] = tray_status;
      page[R_STICKY] = tray_status;
      page[R_TYPE] = nodisc_type;
      param_fill = 0;
      result_count = 0;
      result_position = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PAGE_BASE:    base = val[ADDR_W-1:0];
        CFG_MEDIA:        media = val[0];
        CFG_READY_VALUE:  ready_value = val[BYTE_W-1:0];
        CFG_TRAY_STATUS:  tray_status = val[BYTE_W-1:0];
        CFG_PAUSE_STATUS: pause_status = val[BYTE_W-1:0];
        CFG_NODISC_TYPE:  nodisc_type = val[BYTE_W-1:0];
        CFG_RCFG_OPCODE:  rcfg_opcode = val[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function reply_t predict_reply(access_t a);
      reply_t            r;
      logic [ADDR_W-1:0] phys;
      logic [ADDR_W-1:0] diff;
      logic [ADDR_W:0]   lo;
      logic [BYTE_W-1:0] off;
      logic [BYTE_W-1:0] bits;
      logic [31:0]       sec;
      logic [31:0]       cnt;
      logic              issued;
      r = '0;
      if (a.opcode == OP_INSERT) begin
        page[R_TYPE] = a.write_data;
        page[R_STATUS] = pause_status;
        page[R_STICKY] = page[R_STICKY] | pause_status;
        page[R_READY] = ready_value;
        return r;
      end
      if (a.opcode == OP_NONE) return r;
      phys = a.bus_address[ADDR_W-1:0];
      lo = {1'b0, base};
      if ({1'b0, phys} < lo || {1'b0, phys} >= lo + WINDOW_SIZE) return r;
      r.hit = 1'b1;
      diff = phys - base;
      off = diff[BYTE_W-1:0];
      if (a.opcode == OP_READ) begin
        case (off)
          R_ERROR: begin
            r.read_data = page[off];
            page[off] = '0;
          end
          R_BREAK: r.read_data = '0;
          R_SDATA: r.read_data = (result_position >= result_count) ? NODATA_BIT : '0;
          R_SRESULT: begin
            if (result_position < result_count) result_position++;
            r.read_data = '0;
          end
          default: r.read_data = page[off];
        endcase
        return r;
      end
      case (off)
        R_READY: begin
          if (param_fill < PARAM_DEPTH) begin
            params[param_fill] = a.write_data;
            param_fill++;
          end
        end
        R_ISTAT: page[off] = page[off] & ~a.write_data;
        // not modelled; the S parameter bytes never come back
        R_SDATA: ;
        R_SCMD: begin
          page[off] = a.write_data;
          result_count = (a.write_data == rcfg_opcode) ? RESULT_LEN : 1;
          result_position = 0;
        end
        default: begin
          page[off] = a.write_data;
          if (off == R_NCMD) begin
            bits = ISTAT_DONE;
            if (a.write_data == NCMD_READ_A || a.write_data == NCMD_READ_B) begin
              issued = 1'b0;
              if (media && param_fill >= READ_PARAMS) begin
                sec = {params[3], params[2], params[1], params[0]};
                cnt = {params[7], params[6], params[5], params[4]};
                if (cnt > MAX_SECTORS) cnt = MAX_SECTORS;
                if (cnt != 0) begin
                  issued = 1'b1;
                  r.read_issued = 1'b1;
                  r.start_sector = sec;
                  r.sector_count = cnt[CNT_W-1:0];
                  if (a.transfer_ok) bits = bits | ISTAT_DATA;
                  else page[R_ERROR] = ERR_ABORT;
                end
              end
              if (!issued) page[R_ERROR] = ERR_ABORT;
            end
            page[R_ISTAT] = page[R_ISTAT] | bits;
            r.irq_pulse = 1'b1;
            param_fill = 0;
          end
        end
      endcase
      return r;
    endfunction

    function void note_access(access_t a);
      replies_due.push_back(predict_reply(a));
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("reply with no access outstanding");
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      compare("read_data", 32'(want.read_data), 32'(got.read_data));
      compare("hit", 32'(want.hit), 32'(got.hit));
      compare("irq_pulse", 32'(want.irq_pulse), 32'(got.irq_pulse));
      compare("read_issued", 32'(want.read_issued), 32'(got.read_issued));
      compare("start_sector", want.start_sector, got.start_sector);
      compare("sector_count", 32'(want.sector_count), 32'(got.sector_count));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_opcode;
  logic [BUS_W-1:0]      in_bus_address;
  logic [BYTE_W-1:0]     in_write_data;
  logic                  in_transfer_ok;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_read_data;
  logic                  out_hit;
  logic                  out_irq_pulse;
  logic                  out_read_issued;
  logic [BUS_W-1:0]      out_start_sector;
  logic [CNT_W-1:0]      out_sector_count;

  page_scoreboard    sb;
  bit                idle_on = 1'b1;
  int                accesses_sent = 0;
  logic [ADDR_W-1:0] cur_base = RST_PAGE_BASE;
  logic [BYTE_W-1:0] cur_rcfg = RST_RCFG_OPCODE;

  disc_drive_command_register_page i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_bus_address   (in_bus_address),
    .in_write_data    (in_write_data),
    .in_transfer_ok   (in_transfer_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_hit          (out_hit),
    .out_irq_pulse    (out_irq_pulse),
    .out_read_issued  (out_read_issued),
    .out_start_sector (out_start_sector),
    .out_sector_count (out_sector_count)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 34);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_reply(reply_t'{out_read_data, out_hit, out_irq_pulse, out_read_issued,
                              out_start_sector, out_sector_count});
    end
  end

  task automatic send_at(input op_t op, input logic [BUS_W-1:0] addr,
                         input logic [BYTE_W-1:0] data, input logic ok);
    access_t a;
    a.opcode = op;
    a.bus_address = addr;
    a.write_data = data;
    a.transfer_ok = ok;
    while (idle_on && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= a.opcode;
    in_bus_address <= a.bus_address;
    in_write_data <= a.write_data;
    in_transfer_ok <= a.transfer_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_access(a);
    accesses_sent++;
    @(negedge clk);
  endtask

  task automatic poke(input op_t op, input logic [BYTE_W-1:0] off,
                      input logic [BYTE_W-1:0] data, input logic ok);
    logic [ADDR_W:0] spot;
    spot = {1'b0, cur_base} + {18'd0, 4'($urandom_range(0, 15)), off};
    send_at(op, {3'($urandom_range(0, 7)), spot[ADDR_W-1:0]}, data, ok);
  endtask

  task automatic wait_replies();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_phase(input logic [ADDR_W-1:0] base, input logic media,
                           input logic [BYTE_W-1:0] ready, input logic [BYTE_W-1:0] tray,
                           input logic [BYTE_W-1:0] pause, input logic [BYTE_W-1:0] nodisc,
                           input logic [BYTE_W-1:0] rcfg);
    write_reg(CFG_PAGE_BASE, base);
    write_reg(CFG_MEDIA, 29'(media));
    write_reg(CFG_READY_VALUE, 29'(ready));
    write_reg(CFG_TRAY_STATUS, 29'(tray));
    write_reg(CFG_PAUSE_STATUS, 29'(pause));
    write_reg(CFG_NODISC_TYPE, 29'(nodisc));
    write_reg(CFG_RCFG_OPCODE, 29'(rcfg));
    cfg_we <= 1'b0;
    cur_base = base;
    cur_rcfg = rcfg;
  endtask

  task automatic random_episode();
    int                sel;
    int                n;
    logic [31:0]       cnt;
    logic [63:0]       burst;
    logic [BYTE_W-1:0] cmd;
    logic [ADDR_W-1:0] edge_addr;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      case ($urandom_range(0, 3))
        0: cnt = $urandom_range(1, 40);
        1: cnt = 0;
        2: cnt = $urandom;
        default: cnt = $urandom_range(MAX_SECTORS - 1, MAX_SECTORS + 1);
      endcase
      burst = {cnt, 32'($urandom)};
      n = ($urandom_range(0, 3) != 0) ? READ_PARAMS : $urandom_range(0, PARAM_DEPTH + 2);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) poke(OP_READ, 8'($urandom_range(0, 31)), '0, 1'b0);
        poke(OP_WRITE, R_READY, (i < READ_PARAMS) ? burst[8*i +: 8] : 8'($urandom),
             1'($urandom));
      end
      if ($urandom_range(0, 4) == 0) cmd = 8'($urandom);
      else cmd = $urandom_range(0, 1) ? NCMD_READ_A : NCMD_READ_B;
      poke(OP_WRITE, R_NCMD, cmd, 1'($urandom));
      if ($urandom_range(0, 1)) poke(OP_READ, R_ERROR, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 1)) poke(OP_READ, R_ISTAT, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 2) == 0) poke(OP_WRITE, R_ISTAT, 8'($urandom), 1'($urandom));
    end else if (sel < 50) begin
      repeat ($urandom_range(0, 3)) poke(OP_WRITE, R_SDATA, 8'($urandom), 1'($urandom));
      cmd = $urandom_range(0, 1) ? cur_rcfg : 8'($urandom);
      poke(OP_WRITE, R_SCMD, cmd, 1'($urandom));
      repeat ($urandom_range(0, 20)) begin
        poke(OP_READ, ($urandom_range(0, 3) == 0) ? R_SDATA : R_SRESULT,
             8'($urandom), 1'($urandom));
      end
    end else if (sel < 58) begin
      send_at(OP_INSERT, $urandom, 8'($urandom), 1'($urandom));
    end else if (sel < 64) begin
      case ($urandom_range(0, 2))
        0: edge_addr = 29'($urandom);
        1: edge_addr = cur_base - 29'd1;
        default: edge_addr = cur_base + 29'(WINDOW_SIZE);
      endcase
      send_at($urandom_range(0, 1) ? OP_WRITE : OP_READ,
              {3'($urandom_range(0, 7)), edge_addr}, 8'($urandom), 1'($urandom));
    end else if (sel < 66) begin
      send_at(OP_NONE, $urandom, 8'($urandom), 1'($urandom));
    end else begin
      poke($urandom_range(0, 1) ? OP_WRITE : OP_READ,
           ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 31)) : 8'($urandom),
           8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int          goal;
    logic [63:0] burst;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_opcode = OP_NONE;
    in_bus_address = '0;
    in_write_data = '0;
    in_transfer_ok = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values of the special bytes
    poke(OP_READ, R_READY, 8'h00, 1'b0);
    poke(OP_READ, R_STATUS, 8'h00, 1'b0);
    poke(OP_READ, R_STICKY, 8'h00, 1'b0);
    poke(OP_READ, R_TYPE, 8'h00, 1'b0);
    send_at(OP_NONE, $urandom, 8'($urandom), 1'b1);
    wait_replies();

    set_phase('0, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00);
    send_at(OP_INSERT, 32'hFFFF_FFFF, 8'hA5, 1'b1);
    poke(OP_READ, R_TYPE, 8'h00, 1'b0);
    poke(OP_WRITE, R_NCMD, NCMD_READ_A, 1'b1);
    poke(OP_READ, R_ERROR, 8'h00, 1'b0);
    poke(OP_READ, R_ERROR, 8'h00, 1'b0);
    // all-ones start sector, count above the clamp
    burst = 64'h0000_1001_FFFF_FFFF;
    for (int i = 0; i < READ_PARAMS; i++) poke(OP_WRITE, R_READY, burst[8*i +: 8], 1'b0);
    poke(OP_WRITE, R_NCMD, NCMD_READ_B, 1'b1);
    poke(OP_READ, R_ISTAT, 8'h00, 1'b0);
    poke(OP_WRITE, R_ISTAT, 8'hFF, 1'b0);
    poke(OP_WRITE, R_SCMD, 8'h00, 1'b0);
    poke(OP_READ, R_SDATA, 8'h00, 1'b0);
    poke(OP_READ, R_SRESULT, 8'h00, 1'b0);
    poke(OP_READ, R_BREAK, 8'h00, 1'b0);
    send_at(OP_READ, 32'hFFFF_FFFF, 8'hFF, 1'b0);

    for (int p = 0; p < 5; p++) begin
      wait_replies();
      idle_on = (p != 1);
      case (p)
        0: begin
          set_phase(29'h1FFF_F000, 1'b1, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF);
          goal = accesses_sent + 400;
        end
        1: begin
          set_phase(29'($urandom), 1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
          goal = accesses_sent + 400;
        end
        2: begin
          set_phase(29'h1FFF_FFFF, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00);
          goal = accesses_sent + 40;
        end
        3: begin
          set_phase(29'($urandom), 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
          goal = accesses_sent + 300;
        end
        default: begin
          set_phase('0, 1'b1, RST_READY_VALUE, RST_TRAY_STATUS, RST_PAUSE_STATUS,
                    RST_NODISC_TYPE, RST_RCFG_OPCODE);
          goal = accesses_sent + 460;
        end
      endcase
      while (accesses_sent < goal) random_episode();
    end

    wait_replies();
    if (sb.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ddcrp_pkg.sv
hw/rtl/ddcrp_ram.sv
hw/rtl/ddcrp_ctrl.sv
hw/rtl/ddcrp_dp.sv
hw/rtl/disc_drive_command_register_page.sv
hw/rtl/ddcrp_checker.sv
bench/tb_top.sv
